// ----- design/gfau_pkg.sv -----
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared types, constants and constant tables for the GF(2^8) arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

    localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;  // x^4+x^3+x^2+1
    localparam logic [7:0] FIELD_TOP_BIT  = 8'h80;
    localparam logic [7:0] FIELD_ORDER_M1 = 8'd255;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_POW = 3'd4,
        CMD_INV = 3'd5
    } gfau_cmd_t;

    // How the final stage forms its output byte.
    typedef enum logic [2:0] {
        KIND_ZERO = 3'b001,
        KIND_XOR  = 3'b010,
        KIND_EXP  = 3'b100
    } gfau_kind_t;

    typedef logic [7:0] gf_table_t [256];

    // Antilog: entry i is alpha^i; entry 255 wraps to 1.
    function automatic gf_table_t build_exp();
        gf_table_t   t;
        logic [7:0]  x;
        x = 8'h01;
        for (int i = 0; i < 256; i++) begin
            t[i] = x;
            if ((x & FIELD_TOP_BIT) != 8'h00) begin
                x = {x[6:0], 1'b0} ^ FIELD_POLY_LOW;
            end else begin
                x = {x[6:0], 1'b0};
            end
        end
        return t;
    endfunction

    // Log: inverse of the antilog over alpha^0..alpha^254; log of zero is unused.
    function automatic gf_table_t build_log();
        gf_table_t e;
        gf_table_t l;
        e = build_exp();
        l = '{default: 8'h00};
        for (int i = 0; i < 255; i++) begin
            l[e[i]] = i[7:0];
        end
        return l;
    endfunction

    localparam gf_table_t EXP_TABLE = build_exp();
    localparam gf_table_t LOG_TABLE = build_log();

    typedef struct packed {
        gfau_kind_t  kind;
        gfau_cmd_t   cmd;
        logic [7:0]  log_a;
        logic [7:0]  log_b;
        logic [7:0]  expo;
        logic [7:0]  xor_val;
    } s1_t;

    typedef struct packed {
        gfau_kind_t  kind;
        logic [15:0] raw;
        logic [7:0]  xor_val;
    } s2_t;

    typedef struct packed {
        gfau_kind_t  kind;
        logic [7:0]  idx;
        logic [7:0]  xor_val;
    } s3_t;

endpackage

// ----- design/gfau_log_stage.sv -----
// ----------------------------------------------------------------------------
// gfau_log_stage
// Decode the operation, flag zero operands and look up both logarithms.
// ----------------------------------------------------------------------------
module gfau_log_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       in_cmd,
    input  logic [7:0]       in_a,
    input  logic [7:0]       in_b,
    output logic             out_valid,
    input  logic             out_ready,
    output gfau_pkg::s1_t    out_data
);
    import gfau_pkg::*;

    logic valid_reg, valid_next;
    s1_t  data_reg, data_next;
    logic zero_a, zero_b;

    assign zero_a   = (in_a == 8'h00);
    assign zero_b   = (in_b == 8'h00);
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.cmd     = gfau_cmd_t'(in_cmd);
        data_next.log_a   = LOG_TABLE[in_a];
        data_next.log_b   = LOG_TABLE[in_b];
        data_next.expo    = in_b;
        data_next.xor_val = in_a ^ in_b;
        case (in_cmd)
            CMD_ADD, CMD_SUB: begin
                data_next.kind = KIND_XOR;
            end
            CMD_MUL, CMD_DIV: begin
                data_next.kind = (zero_a || zero_b) ? KIND_ZERO : KIND_EXP;
            end
            CMD_POW, CMD_INV: begin
                data_next.kind = zero_a ? KIND_ZERO : KIND_EXP;
            end
            default: begin
                data_next.kind = KIND_ZERO;
            end
        endcase
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/gfau_exp_reduce.sv -----
// ----------------------------------------------------------------------------
// gfau_exp_reduce
// Form the result exponent (sum, difference or log times exponent) and
// reduce it modulo 255 over two register stages.
// ----------------------------------------------------------------------------
module gfau_exp_reduce (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  gfau_pkg::s1_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output gfau_pkg::s3_t    out_data
);
    import gfau_pkg::*;

    logic s2_valid_reg, s2_valid_next;
    s2_t  s2_reg, s2_next;
    logic s3_valid_reg, s3_valid_next;
    s3_t  s3_reg, s3_next;
    logic s2_ready, s3_ready;
    logic [8:0] fold1;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;

    // Raw exponent: every form stays below 2^16 and is congruent mod 255.
    always_comb begin
        s2_next.kind    = in_data.kind;
        s2_next.xor_val = in_data.xor_val;
        case (in_data.cmd)
            CMD_MUL: begin
                s2_next.raw = {7'd0, {1'b0, in_data.log_a} + {1'b0, in_data.log_b}};
            end
            CMD_DIV: begin
                s2_next.raw = {7'd0, {1'b0, in_data.log_a}
                                   + {1'b0, FIELD_ORDER_M1 - in_data.log_b}};
            end
            CMD_POW: begin
                s2_next.raw = {8'd0, in_data.log_a} * {8'd0, in_data.expo};
            end
            CMD_INV: begin
                s2_next.raw = {8'd0, FIELD_ORDER_M1 - in_data.log_a};
            end
            default: begin
                s2_next.raw = 16'd0;
            end
        endcase
    end

    // 256 = 1 mod 255: fold the high byte onto the low byte twice.
    assign fold1 = {1'b0, s2_reg.raw[15:8]} + {1'b0, s2_reg.raw[7:0]};

    always_comb begin
        s3_next.kind    = s2_reg.kind;
        s3_next.xor_val = s2_reg.xor_val;
        s3_next.idx     = fold1[7:0] + {7'd0, fold1[8]};
    end

    assign s2_valid_next = s2_ready ? in_valid : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && s2_ready) begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg && s3_ready) begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

endmodule

// ----- design/gfau_result_stage.sv -----
// ----------------------------------------------------------------------------
// gfau_result_stage
// Look up the antilog and select the output byte into the output register.
// ----------------------------------------------------------------------------
module gfau_result_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  gfau_pkg::s3_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_result
);
    import gfau_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] result_reg, result_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        case (in_data.kind)
            KIND_XOR: begin
                result_next = in_data.xor_val;
            end
            KIND_EXP: begin
                result_next = EXP_TABLE[in_data.idx];
            end
            default: begin
                result_next = 8'h00;
            end
        endcase
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- design/gf256_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit_top
// Four-stage pipelined arithmetic unit over GF(2^8), polynomial 0x11D.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out: add/subtract (XOR), multiply,
// divide, power and inverse on bytes of GF(2^8) with field polynomial
// x^8+x^4+x^3+x^2+1 and generator 2. The unit accepts a transaction every
// cycle while m_tready is high; each result passes through the register
// stages log lookup, exponent multiply/sum, modulo-255 fold and antilog
// lookup. Results come out in input order. Any stage that holds
// a transaction stalls only when everything after it is full, so m_tready
// low fills the pipeline and only then drops s_tready. Multiply or divide
// with a zero operand, the inverse of zero and zero to any power give 0;
// unused opcodes 6 and 7 give 0.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [2:0] cmd, [10:3] operand_a, [18:11] operand_b,
                                   // [23:19] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] result
);
    import gfau_pkg::*;

    logic s1_valid, s1_ready;
    s1_t  s1_data;
    logic s3_valid, s3_ready;
    s3_t  s3_data;

    // Stage 1: decode and log lookup.
    gfau_log_stage u_log (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[2:0]),
        .in_a      (s_tdata[10:3]),
        .in_b      (s_tdata[18:11]),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Stages 2 and 3: exponent arithmetic and modulo-255 reduction.
    gfau_exp_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // Stage 4: antilog lookup and output register.
    gfau_result_stage u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s3_valid),
        .in_ready   (s3_ready),
        .in_data    (s3_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata)
    );

    // A ready sink always lets the whole pipeline advance.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // Input back-pressure only once stages 1, 3 and 4 all hold a transaction.
    a_full_before_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid && s3_valid && m_tvalid))
        else $error("input stalled with a bubble in the pipeline");

    // An accepted transaction lands in stage 1 on the next edge.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid)
        else $error("accepted transaction lost at stage 1");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GF(2^8) arithmetic unit, polynomial 0x11D.
// ----------------------------------------------------------------------------
// Drives opcode/operand transactions into the unit, predicts each result
// with a bit-serial field multiplier and square-and-multiply power, and
// compares every output transaction with the oldest prediction. Directed
// corner cases come first, then random traffic under sender bursts, receiver
// stalls, a long output hold-off and a stretch at full rate.
// ----------------------------------------------------------------------------
module tb;
    import gfau_pkg::*;

    // Opcodes 6 and 7 have no operation; the unit answers them with zero.
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int HOLD_CYCLES  = 200;   // long output hold-off
    localparam int DRAIN_LIMIT  = 2000;  // cycles allowed for results to drain
    localparam int SETTLE_TICKS = 12;    // settle time after the last test, before the verdict

    // Receiver behavior between hold-offs.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_mode_t;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [7:0] result;
    } gf_op_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    gf_op_t      pending_results[$];   // predicted results, oldest first
    int          mismatch_count;
    int          burst_left;           // transactions left in the current sender burst
    bit          gaps_on;              // sender inserts idle gaps between bursts
    bit          hold_req;             // ask the receiver for one long hold-off
    ready_mode_t ready_mode;

    gf256_arithmetic_unit_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Field arithmetic predictor
    // ------------------------------------------------------------------------

    // Carry-less product, reducing by the field polynomial on every shift.
    function automatic logic [7:0] gf_mul8(input logic [7:0] x_in, input logic [7:0] y_in);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = x_in;
        for (int k = 0; k < 8; k++) begin
            if (y_in[k]) acc ^= x;
            if ((x & FIELD_TOP_BIT) != 8'h00) x = {x[6:0], 1'b0} ^ FIELD_POLY_LOW;
            else                              x = {x[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Square-and-multiply, exponent MSB first; a zero base always gives zero.
    function automatic logic [7:0] gf_pow8(input logic [7:0] base, input logic [7:0] expo);
        logic [7:0] r;
        if (base == 8'h00) return 8'h00;
        r = 8'h01;
        for (int k = 7; k >= 0; k--) begin
            r = gf_mul8(r, r);
            if (expo[k]) r = gf_mul8(r, base);
        end
        return r;
    endfunction

    // Inverse is the 254th power (group order minus one); zero maps to zero.
    function automatic logic [7:0] gf_inv8(input logic [7:0] x);
        return gf_pow8(x, FIELD_ORDER_M1 - 8'd1);
    endfunction

    function automatic logic [7:0] gf_result(input logic [2:0] cmd, input logic [7:0] a,
                                             input logic [7:0] b);
        case (cmd)
            CMD_ADD, CMD_SUB: return a ^ b;
            CMD_MUL:          return gf_mul8(a, b);
            CMD_DIV:          return (a == 8'h00 || b == 8'h00) ? 8'h00 : gf_mul8(a, gf_inv8(b));
            CMD_POW:          return gf_pow8(a, b);
            CMD_INV:          return gf_inv8(a);
            default:          return 8'h00;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: record accepted inputs, check accepted outputs
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Sample both channels at the rising edge. Push before pop so a
    // prediction is always in place when its result shows up.
    always @(posedge aclk) begin
        gf_op_t op;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                op.cmd       = s_tdata[2:0];
                op.operand_a = s_tdata[10:3];
                op.operand_b = s_tdata[18:11];
                op.result    = gf_result(op.cmd, op.operand_a, op.operand_b);
                pending_results.push_back(op);
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %02h", m_tdata));
                end else begin
                    op = pending_results.pop_front();
                    if (m_tdata !== op.result)
                        report_mismatch($sformatf("cmd %0d a=%02h b=%02h: result %02h, want %02h",
                                        op.cmd, op.operand_a, op.operand_b, m_tdata,
                                        op.result));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: drive m_tready on the falling edge
    // ------------------------------------------------------------------------
    initial begin
        int run_left;
        bit run_ready;
        run_left  = 0;
        run_ready = 1'b1;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // Hold off for a fixed stretch so the pipeline fills and backs up.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    // Alternate ready runs and stall runs of random length.
                    if (run_left == 0) begin
                        run_ready = !run_ready;
                        run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 5);
                    end
                    m_tready <= run_ready;
                    run_left--;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Drop s_tvalid for an idle gap whose length is given by n.
    task automatic idle_cycles(input int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Offer one transaction and hold it until accepted; then, if gaps are on,
    // close the burst with a random idle gap when its count runs out.
    task automatic send_op(input logic [2:0] cmd, input logic [7:0] a, input logic [7:0] b);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, b, a, cmd};
        do @(posedge aclk); while (!s_tready);
        if (gaps_on) begin
            if (burst_left == 0) begin
                idle_cycles($urandom_range(1, 6));
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Bias operands toward the edges of the field.
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly real opcodes, with the two spare codes now and then.
    function automatic logic [2:0] pick_cmd();
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
        return 3'($urandom_range(CMD_ADD, CMD_INV));
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_op(pick_cmd(), pick_operand(), pick_operand());
    endtask

    // Drop valid and wait, bounded, until every predicted result has arrived.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        idle_cycles(1);
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, every opcode, and each zero/identity corner.
    task automatic test_corner_cases();
        gaps_on    = 1'b0;
        ready_mode = READY_ALWAYS;
        send_op(CMD_ADD, 8'h00, 8'h00);
        send_op(CMD_ADD, 8'hFF, 8'hFF);
        send_op(CMD_SUB, 8'hA5, 8'h5A);
        send_op(CMD_MUL, 8'h00, 8'h37);    // zero operand in multiply
        send_op(CMD_MUL, 8'h37, 8'h00);
        send_op(CMD_MUL, 8'h80, 8'h02);    // reduction on the top bit
        send_op(CMD_MUL, 8'hFF, 8'hFF);
        send_op(CMD_DIV, 8'h00, 8'h05);    // zero dividend
        send_op(CMD_DIV, 8'h05, 8'h00);    // zero divisor
        send_op(CMD_DIV, 8'hFF, 8'hFF);
        send_op(CMD_DIV, 8'h01, 8'h53);
        send_op(CMD_POW, 8'h00, 8'h00);    // zero to the zero is zero
        send_op(CMD_POW, 8'h00, 8'hFF);
        send_op(CMD_POW, 8'h07, 8'h00);    // nonzero base, zero exponent
        send_op(CMD_POW, 8'h02, 8'hFF);    // generator to the group order
        send_op(CMD_POW, 8'hFF, 8'h01);
        send_op(CMD_POW, 8'h03, 8'hFE);
        send_op(CMD_INV, 8'h00, 8'hFF);    // inverse of zero
        send_op(CMD_INV, 8'h01, 8'h00);
        send_op(CMD_INV, 8'hFF, 8'hAA);
        send_op(CMD_INV, 8'h8E, 8'h55);
        send_op(CMD_SPARE6, 8'hFF, 8'hFF);
        send_op(CMD_SPARE7, 8'h12, 8'h34);
        wait_for_results();
    endtask

    // Random traffic, bursty sender, randomly stalling receiver.
    task automatic test_random_stalls();
        gaps_on    = 1'b1;
        burst_left = $urandom_range(1, 16);
        ready_mode = READY_RANDOM;
        send_random(400);
        wait_for_results();
    endtask

    // Hold the output off while the sender keeps offering, so the unit fills
    // up and drops s_tready; then release and let everything drain.
    task automatic test_backpressure();
        gaps_on    = 1'b0;
        ready_mode = READY_ALWAYS;
        hold_req   = 1'b1;
        send_random(24);
        wait_for_results();
    endtask

    // Back-to-back transactions with the receiver always ready.
    task automatic test_full_rate();
        gaps_on    = 1'b0;
        ready_mode = READY_ALWAYS;
        send_random(300);
        wait_for_results();
    endtask

    // Bursty sender against a receiver with ready/stall runs.
    task automatic test_random_pattern();
        gaps_on    = 1'b1;
        burst_left = $urandom_range(1, 16);
        ready_mode = READY_PATTERN;
        send_random(450);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        hold_req       = 1'b0;
        ready_mode     = READY_ALWAYS;
        gaps_on        = 1'b0;
        burst_left     = 0;
        mismatch_count = 0;

        // Synchronous reset, released on a falling edge.
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_corner_cases();
        test_random_stalls();
        test_backpressure();
        test_full_rate();
        test_random_pattern();

        // Let any stray output surface before the verdict.
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
design/gfau_pkg.sv
design/gfau_log_stage.sv
design/gfau_exp_reduce.sv
design/gfau_result_stage.sv
design/gf256_arithmetic_unit_top.sv
tb/sv/tb.sv
